FILE: hw/rtl/tpfd_pkg.sv
// Shared types and constants for the three-phase fall detector.
// Holds the phase codes, register indexes, stillness levels and the
// structs passed between the configuration, phase and top-level modules.
`timescale 1ns / 1ps

package tpfd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_FREEFALL = 2'd1,
    PH_IMPACT   = 2'd2
  } phase_t;

  // Configuration write port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_LEVEL      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_LEVEL        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_IMPACT_LEVEL = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_LEVEL      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_DELAY_MS    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_TIMEOUT_MS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_TIMEOUT_MS   = 4'd7;

  // Stillness window: 0.7 g < accel < 1.4 g, rate < 30 deg/s
  localparam logic [15:0] STILL_ACCEL_LOW  = 16'd2867;
  localparam logic [15:0] STILL_ACCEL_HIGH = 16'd5735;
  localparam logic [15:0] STILL_RATE_MAX   = 16'd480;

  // Sample and magnitude widths
  localparam int AXIS_W = 16;
  localparam int ABS_W  = 17;
  localparam int SQ_W   = 32;
  localparam int MAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int IN_W   = 6 * AXIS_W + TIME_W;
  localparam int OUT_W  = 40;

  localparam logic [MAG_W-1:0] ONE_G = 16'd4096;

  typedef struct packed {
    logic [15:0] freefall_level;
    logic [15:0] impact_level;
    logic [15:0] direct_impact_level;
    logic [15:0] rotation_level;
    logic [19:0] cooldown_ms;
    logic [15:0] confirm_delay_ms;
    logic [15:0] freefall_timeout_ms;
    logic [15:0] impact_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic   fall_alert;
    logic   rotation_seen;
    phase_t phase_now;
  } verdict_t;

endpackage

FILE: hw/rtl/tpfd_cfg.sv
// Configuration register file of the fall detector.
// Decodes the write channel into the threshold and timing registers.
// Depends on tpfd_pkg.
`timescale 1ns / 1ps

module tpfd_cfg import tpfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freefall_level      <= 16'd1638;
      cfg.impact_level        <= 16'd10240;
      cfg.direct_impact_level <= 16'd14336;
      cfg.rotation_level      <= 16'd3200;
      cfg.cooldown_ms         <= 20'd30000;
      cfg.confirm_delay_ms    <= 16'd1000;
      cfg.freefall_timeout_ms <= 16'd1000;
      cfg.impact_timeout_ms   <= 16'd4000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FREEFALL_LEVEL:      cfg.freefall_level      <= cfg_data[15:0];
        CFG_IMPACT_LEVEL:        cfg.impact_level        <= cfg_data[15:0];
        CFG_DIRECT_IMPACT_LEVEL: cfg.direct_impact_level <= cfg_data[15:0];
        CFG_ROTATION_LEVEL:      cfg.rotation_level      <= cfg_data[15:0];
        CFG_COOLDOWN_MS:         cfg.cooldown_ms         <= cfg_data;
        CFG_CONFIRM_DELAY_MS:    cfg.confirm_delay_ms    <= cfg_data[15:0];
        CFG_FREEFALL_TIMEOUT_MS: cfg.freefall_timeout_ms <= cfg_data[15:0];
        CFG_IMPACT_TIMEOUT_MS:   cfg.impact_timeout_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tpfd_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Floor root of a 32-bit operand, started by start and signalled by done.
// Depends on tpfd_pkg.
`timescale 1ns / 1ps

module tpfd_isqrt import tpfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  operand,
  output logic             done,
  output logic [MAG_W-1:0] root
);

  logic            busy;
  logic [3:0]      step;
  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;
  logic            fits;

  always_comb begin
    bitv  = SQ_W'(1) << {step, 1'b0};
    trial = {1'b0, res} + {1'b0, bitv};
    fits  = {1'b0, rem} >= trial;
  end

  assign root = res[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 4'd15;
        rem  <= operand;
        res  <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - trial[SQ_W-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        step <= step - 4'd1;
        if (step == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/tpfd_phase.sv
// Idle / free-fall / impact phase machine of the fall detector.
// Holds phase, phase start time, last alert time and rotation flag.
// Depends on tpfd_pkg.
`timescale 1ns / 1ps

module tpfd_phase import tpfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  logic [MAG_W-1:0]  accel,
  input  logic [MAG_W-1:0]  rate,
  input  logic [TIME_W-1:0] now,
  input  cfg_t              cfg,
  output verdict_t          verdict
);

  phase_t              phase;
  logic [TIME_W-1:0]   phase_begin;
  logic [TIME_W-1:0]   last_alert;
  logic                alerted_before;
  logic                rotation_flag;

  phase_t              phase_next;
  logic [TIME_W-1:0]   phase_begin_next;
  logic [TIME_W-1:0]   last_alert_next;
  logic                alerted_before_next;
  logic                rotation_flag_next;
  logic                alert;

  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   since_alert;
  logic                cooling;
  logic                rotating;
  logic                still;

  always_comb begin
    elapsed     = now - phase_begin;
    since_alert = now - last_alert;
    cooling     = alerted_before && (since_alert < {12'd0, cfg.cooldown_ms});
    rotating    = rate > cfg.rotation_level;
    still       = (accel > STILL_ACCEL_LOW) && (accel < STILL_ACCEL_HIGH) &&
                  (rate < STILL_RATE_MAX);

    phase_next          = phase;
    phase_begin_next    = phase_begin;
    last_alert_next     = last_alert;
    alerted_before_next = alerted_before;
    rotation_flag_next  = rotation_flag;
    alert               = 1'b0;

    if (!cooling) begin
      case (phase)
        PH_FREEFALL: begin
          if (rotating) rotation_flag_next = 1'b1;
          if (elapsed > {16'd0, cfg.freefall_timeout_ms}) begin
            phase_next = PH_IDLE;
          end else if (accel > cfg.impact_level) begin
            phase_next       = PH_IMPACT;
            phase_begin_next = now;
          end
        end
        PH_IMPACT: begin
          if (elapsed > {16'd0, cfg.impact_timeout_ms}) begin
            phase_next = PH_IDLE;
          end else if (elapsed >= {16'd0, cfg.confirm_delay_ms} && still) begin
            phase_next          = PH_IDLE;
            last_alert_next     = now;
            alerted_before_next = 1'b1;
            alert               = 1'b1;
          end
        end
        default: begin
          // idle, and the unused code treated as idle
          phase_next = PH_IDLE;
          if (accel < cfg.freefall_level) begin
            phase_next         = PH_FREEFALL;
            phase_begin_next   = now;
            rotation_flag_next = 1'b0;
          end else if (accel > cfg.direct_impact_level) begin
            phase_next         = PH_IMPACT;
            phase_begin_next   = now;
            rotation_flag_next = rotating;
          end
        end
      endcase
    end

    verdict.fall_alert    = alert;
    verdict.rotation_seen = rotation_flag_next;
    verdict.phase_now     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      phase_begin    <= '0;
      last_alert     <= '0;
      alerted_before <= 1'b0;
      rotation_flag  <= 1'b0;
    end else if (commit) begin
      phase          <= phase_next;
      phase_begin    <= phase_begin_next;
      last_alert     <= last_alert_next;
      alerted_before <= alerted_before_next;
      rotation_flag  <= rotation_flag_next;
    end
  end

endmodule

FILE: hw/rtl/three_phase_fall_detector.sv
// Three-phase fall detector: accel and gyro magnitudes, ring averages, phase machine.
// Per sample, for the accel vector and then the gyro vector: squares on the shared
// multiplier and a square root; then the two ring means, the phase step and the output.
// One sample at a time: s_tready stays low until the result is loaded; a stalled output holds it.
// Synchronous reset restores default registers, rings (accel 1 g, gyro 0) and idle phase.
// Depends on tpfd_pkg, tpfd_cfg, tpfd_isqrt, tpfd_phase.
`timescale 1ns / 1ps

module three_phase_fall_detector import tpfd_pkg::*; #(
  parameter int SMOOTH_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // fall_alert, rotation_seen, phase_now[1:0], accel_average[15:0],
  // rate_average[15:0], 4 zero bits
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W      = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int SUM_W       = MAG_W + $clog2(SMOOTH_DEPTH);
  localparam int RECIP_SHIFT = SUM_W + $clog2(SMOOTH_DEPTH);
  localparam int RECIP       = (2 ** RECIP_SHIFT + SMOOTH_DEPTH - 1) / SMOOTH_DEPTH;
  localparam int MUL_W       = (RECIP_SHIFT > ABS_W) ? RECIP_SHIFT : ABS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_AVG,
    ST_PHASE
  } state_t;

  state_t             state;
  logic [1:0]         cnt;
  logic               grp;
  logic [ABS_W-1:0]   abs_q [6];
  logic [TIME_W-1:0]  now;
  logic [SQ_W-1:0]    sumsq;
  logic [2*MUL_W-1:0] prod;
  logic [MAG_W-1:0]   accel_ring [SMOOTH_DEPTH];
  logic [MAG_W-1:0]   rate_ring [SMOOTH_DEPTH];
  logic [SLOT_W-1:0]  slot;
  logic [SUM_W-1:0]   accel_sum;
  logic [SUM_W-1:0]   rate_sum;
  logic [MAG_W-1:0]   accel_mean;
  logic [MAG_W-1:0]   rate_mean;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [ABS_W-1:0]   abs_sel;
  logic               root_start;
  logic [SQ_W-1:0]    root_operand;
  logic               root_done;
  logic [MAG_W-1:0]   root;
  logic               out_free;
  logic               commit;
  cfg_t               cfg;
  verdict_t           verdict;

  function automatic logic [ABS_W-1:0] abs16(input logic [AXIS_W-1:0] v);
    logic [ABS_W-1:0] ext;
    ext = {1'b0, v};
    return v[AXIS_W-1] ? (ABS_W'(17'h10000) - ext) : ext;
  endfunction

  tpfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpfd_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (root_operand),
    .done    (root_done),
    .root    (root)
  );

  tpfd_phase u_phase (
    .clk     (clk),
    .rst     (rst),
    .commit  (commit),
    .accel   (accel_mean),
    .rate    (rate_mean),
    .now     (now),
    .cfg     (cfg),
    .verdict (verdict)
  );

  assign s_tready     = (state == ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  assign commit       = (state == ST_PHASE) && out_free;
  assign root_start   = (state == ST_SQ) && (cnt == 2'd3);
  assign root_operand = sumsq + prod[SQ_W-1:0];

  always_comb begin
    case ({grp, cnt})
      3'b000:  abs_sel = abs_q[0];
      3'b001:  abs_sel = abs_q[1];
      3'b010:  abs_sel = abs_q[2];
      3'b100:  abs_sel = abs_q[3];
      3'b101:  abs_sel = abs_q[4];
      3'b110:  abs_sel = abs_q[5];
      default: abs_sel = '0;
    endcase
    if (state == ST_AVG) begin
      mul_a = (cnt == 2'd0) ? MUL_W'(accel_sum) : MUL_W'(rate_sum);
      mul_b = MUL_W'(RECIP);
    end else begin
      mul_a = MUL_W'(abs_sel);
      mul_b = MUL_W'(abs_sel);
    end
  end

  // Shared multiplier: squares, then reciprocal scaling for the ring means
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      grp       <= 1'b0;
      slot      <= '0;
      accel_sum <= SUM_W'(SMOOTH_DEPTH * 4096);
      rate_sum  <= '0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < SMOOTH_DEPTH; i++) begin
        accel_ring[i] <= ONE_G;
        rate_ring[i]  <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && !commit) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 6; i++) begin
              abs_q[i] <= abs16(s_tdata[i*AXIS_W +: AXIS_W]);
            end
            now   <= s_tdata[6*AXIS_W +: TIME_W];
            grp   <= 1'b0;
            cnt   <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          // product of axis cnt-1 arrives while axis cnt is issued
          if (cnt == 2'd0) begin
            sumsq <= '0;
          end else begin
            sumsq <= sumsq + prod[SQ_W-1:0];
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            cnt <= '0;
            if (!grp) begin
              accel_ring[slot] <= root;
              accel_sum        <= accel_sum - SUM_W'(accel_ring[slot]) + SUM_W'(root);
              grp              <= 1'b1;
              state            <= ST_SQ;
            end else begin
              rate_ring[slot] <= root;
              rate_sum        <= rate_sum - SUM_W'(rate_ring[slot]) + SUM_W'(root);
              slot            <= (slot == SLOT_W'(SMOOTH_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
              state           <= ST_AVG;
            end
          end
        end
        ST_AVG: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) accel_mean <= prod[RECIP_SHIFT +: MAG_W];
          if (cnt == 2'd2) begin
            rate_mean <= prod[RECIP_SHIFT +: MAG_W];
            state     <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          // hold until the output register is free, then transfer the result
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, rate_mean, accel_mean, verdict.phase_now,
                         verdict.rotation_seen, verdict.fall_alert};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
